/* hw/rtl/sfd_pkg.sv */
// Shared types and constants for the screen frame deframer.
`default_nettype none
package sfd_pkg;

	localparam logic [7:0] CMD_ONE_BYTE_ADDR = 8'h81;
	localparam logic [7:0] CMD_TWO_BYTE_ADDR = 8'h83;
	localparam logic [7:0] LEN_OVERHEAD      = 8'd6;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;

	// register index, taken from paddr[2]
	localparam logic REG_HEADER_FIRST  = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	localparam logic KIND_CONTENT = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  command_code;
		logic [15:0] var_address;
		logic [7:0]  frame_len;
		logic [7:0]  content_len_byte;
		logic [15:0] check_word;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/sfd_parser.sv */
// Per-byte frame parser: phase state, captured header fields, result decode.
`default_nettype none
module sfd_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_take,
	input  wire logic [7:0]      in_byte,
	input  wire logic [7:0]      header_first,
	input  wire logic [7:0]      header_second,
	output logic                 res_valid,
	output sfd_pkg::result_t     res
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_CMD     = 3'd2,
		PH_ADDR    = 3'd3,
		PH_CLEN    = 3'd4,
		PH_CONTENT = 3'd5,
		PH_CHECK   = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sub_q, sub_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] address_q, address_d;
	logic [7:0]  clen_q, clen_d;
	logic [7:0]  check_high_q, check_high_d;
	logic [7:0]  needed;
	logic [7:0]  sub_inc;

	assign needed  = (length_q > sfd_pkg::LEN_OVERHEAD) ? (length_q - sfd_pkg::LEN_OVERHEAD)
		: 8'd1;
	assign sub_inc = sub_q + 8'd1;

	always_comb begin
		phase_d      = phase_q;
		sub_d        = sub_q;
		length_d     = length_q;
		command_d    = command_q;
		address_d    = address_q;
		clen_d       = clen_q;
		check_high_d = check_high_q;
		res_valid    = 1'b0;
		res.kind             = sfd_pkg::KIND_CONTENT;
		res.data_byte        = 8'h00;
		res.byte_index       = sub_q;
		res.command_code     = command_q;
		res.var_address      = address_q;
		res.frame_len        = length_q;
		res.content_len_byte = clen_q;
		res.check_word       = 16'h0000;
		unique case (phase_q)
			PH_HUNT: begin
				// first header byte causes no phase change; it also wins when both are equal
				if (in_byte != header_first && in_byte == header_second)
					phase_d = PH_LEN;
			end
			PH_LEN: begin
				length_d = in_byte;
				phase_d  = PH_CMD;
			end
			PH_CMD: begin
				command_d = in_byte;
				sub_d     = 8'd0;
				if (in_byte == sfd_pkg::CMD_ONE_BYTE_ADDR
						|| in_byte == sfd_pkg::CMD_TWO_BYTE_ADDR)
					phase_d = PH_ADDR;
				else
					phase_d = PH_HUNT;
			end
			PH_ADDR: begin
				if (command_q == sfd_pkg::CMD_ONE_BYTE_ADDR) begin
					address_d = {8'h00, in_byte};
					sub_d     = 8'd0;
					phase_d   = PH_CLEN;
				end else if (sub_q == 8'd0) begin
					address_d = {in_byte, 8'h00};
					sub_d     = 8'd1;
				end else begin
					address_d = {address_q[15:8], in_byte};
					sub_d     = 8'd0;
					phase_d   = PH_CLEN;
				end
			end
			PH_CLEN: begin
				clen_d  = in_byte;
				sub_d   = 8'd0;
				phase_d = PH_CONTENT;
			end
			PH_CONTENT: begin
				res_valid     = 1'b1;
				res.data_byte = in_byte;
				if (sub_inc >= needed) begin
					sub_d   = 8'd0;
					phase_d = PH_CHECK;
				end else begin
					sub_d = sub_inc;
				end
			end
			PH_CHECK: begin
				if (sub_q == 8'd0) begin
					check_high_d = in_byte;
					sub_d        = 8'd1;
				end else begin
					res_valid      = 1'b1;
					res.kind       = sfd_pkg::KIND_DONE;
					res.byte_index = needed;
					res.check_word = {check_high_q, in_byte};
					sub_d          = 8'd0;
					phase_d        = PH_HUNT;
				end
			end
			default: begin
				sub_d   = 8'd0;
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			sub_q        <= 8'd0;
			length_q     <= 8'd0;
			command_q    <= 8'd0;
			address_q    <= 16'd0;
			clen_q       <= 8'd0;
			check_high_q <= 8'd0;
		end else if (in_take) begin
			phase_q      <= phase_d;
			sub_q        <= sub_d;
			length_q     <= length_d;
			command_q    <= command_d;
			address_q    <= address_d;
			clen_q       <= clen_d;
			check_high_q <= check_high_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/screen_frame_deframer.sv */
// Top level of the screen reply-frame deframer: config registers, parser, output register.
//
//  channel  | dir | payload                                       | accepted when
//  ---------+-----+-----------------------------------------------+------------------------------
//  s_*      | in  | tdata[7:0] rx_byte                            | s_tvalid & s_tready
//  m_*      | out | tdata content/frame fields, tuser[0] kind     | m_tvalid & m_tready
//  APB      | in  | 0x0 header_first, 0x4 header_second           | psel & penable & pwrite
//
// One received byte per cycle while s_tready is high. Each byte is decoded in the same cycle
// it is taken, updating the parser registers and loading the output register when it yields
// an item. s_tready is high while the output register is empty or being drained.
// Reset clears the parse phase to hunting and the header registers to 0x5A / 0xA5.
// A stalled output holds its item; no input is lost or taken meanwhile.
`default_nettype none
module screen_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] data_byte, [15:8] byte_index, [23:16] command_code, [39:24] var_address,
	// [47:40] frame_len, [55:48] content_len_byte, [71:56] check_word
	output logic [71:0]      m_tdata,
	output logic [0:0]       m_tuser,   // [0] kind
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic              cfg_wr;
	logic [7:0]        header_first_q;
	logic [7:0]        header_second_q;
	logic              take;
	logic              res_valid;
	sfd_pkg::result_t  res;
	logic              out_valid_q;
	sfd_pkg::result_t  out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == sfd_pkg::REG_HEADER_SECOND) ? {24'd0, header_second_q}
		: {24'd0, header_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= sfd_pkg::HEADER_FIRST_RST;
			header_second_q <= sfd_pkg::HEADER_SECOND_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == sfd_pkg::REG_HEADER_FIRST)
				header_first_q <= pwdata[7:0];
			else
				header_second_q <= pwdata[7:0];
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	sfd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_take       (take),
		.in_byte       (s_tdata),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.check_word, out_q.content_len_byte, out_q.frame_len,
		out_q.var_address, out_q.command_code, out_q.byte_index, out_q.data_byte};

	a_done_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == sfd_pkg::KIND_DONE |-> m_tdata[7:0] == 8'h00)
		else $error("frame-done item carries content data");

	a_content_no_check: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == sfd_pkg::KIND_CONTENT |-> m_tdata[71:56] == 16'h0000)
		else $error("content item carries a check word");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held off without a stalled output");

	a_item_cmd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:16] == sfd_pkg::CMD_ONE_BYTE_ADDR
			|| m_tdata[23:16] == sfd_pkg::CMD_TWO_BYTE_ADDR)
		else $error("item emitted for an unknown command");

endmodule
`default_nettype wire

/* sim/screen_frame_deframer_tb.sv */
// Self-checking testbench for screen_frame_deframer: directed, then random frames under idles/stalls.
`timescale 1ns / 100ps

module screen_frame_deframer_tb;

	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef enum logic [2:0] {
		PH_HUNT, PH_LEN, PH_CMD, PH_ADDR, PH_CLEN, PH_BODY, PH_CHECK
	} parse_phase_e;

	typedef struct {
		logic [7:0]       rx;
		bit               typed;
		sfd_pkg::result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	// [7:0] data_byte, [15:8] byte_index, [23:16] command_code, [39:24] var_address,
	// [47:40] frame_len, [55:48] content_len_byte, [71:56] check_word
	logic [71:0] m_tdata;
	logic [0:0]  m_tuser;   // [0] kind
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// deframer state as predicted
	parse_phase_e ph;
	logic [7:0]   hdr_first;
	logic [7:0]   hdr_second;
	logic [7:0]   sub_cnt;
	logic [7:0]   frm_len;
	logic [7:0]   cmd_byte;
	logic [15:0]  var_addr;
	logic [7:0]   clen_byte;
	logic [7:0]   chk_hi;

	sfd_pkg::result_t frame_q[$];
	stim_row_t        stim_rows[$];
	int unsigned      fails;
	int unsigned      cycles;
	int unsigned      deep_items;
	int unsigned      src_idle_pct;
	int unsigned      sink_stall_pct;

	screen_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] content_count();
		return (frm_len > sfd_pkg::LEN_OVERHEAD) ? frm_len - sfd_pkg::LEN_OVERHEAD : 8'd1;
	endfunction

	function automatic bit deframe_step(input logic [7:0] b, output sfd_pkg::result_t res);
		bit emit;
		emit = 1'b0;
		res = '0;
		case (ph)
			PH_HUNT: begin
				// first-header match wins over second-header match
				if (b != hdr_first && b == hdr_second)
					ph = PH_LEN;
			end
			PH_LEN: begin
				frm_len = b;
				ph = PH_CMD;
			end
			PH_CMD: begin
				cmd_byte = b;
				sub_cnt = 8'd0;
				ph = (b == sfd_pkg::CMD_ONE_BYTE_ADDR || b == sfd_pkg::CMD_TWO_BYTE_ADDR)
					? PH_ADDR : PH_HUNT;
			end
			PH_ADDR: begin
				if (cmd_byte == sfd_pkg::CMD_ONE_BYTE_ADDR) begin
					var_addr = {8'h00, b};
					ph = PH_CLEN;
				end else if (sub_cnt == 8'd0) begin
					var_addr = {b, 8'h00};
					sub_cnt = 8'd1;
				end else begin
					var_addr[7:0] = b;
					sub_cnt = 8'd0;
					ph = PH_CLEN;
				end
			end
			PH_CLEN: begin
				clen_byte = b;
				sub_cnt = 8'd0;
				ph = PH_BODY;
			end
			PH_BODY: begin
				emit = 1'b1;
				res.kind = sfd_pkg::KIND_CONTENT;
				res.data_byte = b;
				res.byte_index = sub_cnt;
				sub_cnt = sub_cnt + 8'd1;
				if (sub_cnt >= content_count()) begin
					sub_cnt = 8'd0;
					ph = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (sub_cnt == 8'd0) begin
					chk_hi = b;
					sub_cnt = 8'd1;
				end else begin
					emit = 1'b1;
					res.kind = sfd_pkg::KIND_DONE;
					res.byte_index = content_count();
					res.check_word = {chk_hi, b};
					sub_cnt = 8'd0;
					ph = PH_HUNT;
				end
			end
			default: begin
				sub_cnt = 8'd0;
				ph = PH_HUNT;
			end
		endcase
		if (emit) begin
			res.command_code = cmd_byte;
			res.var_address = var_addr;
			res.frame_len = frm_len;
			res.content_len_byte = clen_byte;
		end
		return emit;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_error($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
			input sfd_pkg::result_t want = '0);
		sfd_pkg::result_t res;
		bit               got;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata = 8'($urandom_range(255));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		do @(posedge clk); while (!s_tready);
		if (ph != PH_HUNT)
			deep_items++;
		got = deframe_step(b, res);
		if (got)
			frame_q.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {24'h0, val};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == sfd_pkg::REG_HEADER_FIRST)
			hdr_first = val;
		else
			hdr_second = val;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (frame_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_row(input logic [7:0] b);
		stim_row_t r;
		r.rx = b;
		r.typed = 1'b0;
		r.want = '0;
		stim_rows.push_back(r);
	endtask

	task automatic add_row_exp(input logic [7:0] b, input logic kind, input logic [7:0] data,
			input logic [7:0] idx, input logic [7:0] cmd, input logic [15:0] addr,
			input logic [7:0] len, input logic [7:0] clen, input logic [15:0] chk);
		stim_row_t r;
		r.rx = b;
		r.typed = 1'b1;
		r.want.kind = kind;
		r.want.data_byte = data;
		r.want.byte_index = idx;
		r.want.command_code = cmd;
		r.want.var_address = addr;
		r.want.frame_len = len;
		r.want.content_len_byte = clen;
		r.want.check_word = chk;
		stim_rows.push_back(r);
	endtask

	// mostly well-formed frames with random content; some noise, bad commands and cut frames
	task automatic send_frame();
		logic [7:0]  len;
		logic [7:0]  cmd;
		int unsigned body;
		int unsigned cut;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(1))
			send_rx(hdr_first);
		send_rx(hdr_second);
		len = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
		send_rx(len);
		if ($urandom_range(12) == 0)
			cmd = 8'($urandom_range(255));
		else
			cmd = $urandom_range(1) ? sfd_pkg::CMD_ONE_BYTE_ADDR : sfd_pkg::CMD_TWO_BYTE_ADDR;
		send_rx(cmd);
		send_rx(8'($urandom_range(255)));
		if (cmd == sfd_pkg::CMD_TWO_BYTE_ADDR)
			send_rx(8'($urandom_range(255)));
		send_rx(8'($urandom_range(255)));
		body = (len > sfd_pkg::LEN_OVERHEAD) ? len - sfd_pkg::LEN_OVERHEAD : 1;
		cut = ($urandom_range(19) == 0) ? $urandom_range(body) : body + 2;
		for (int i = 0; i < body + 2 && i < cut; i++)
			send_rx(8'($urandom_range(255)));
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		sfd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_q.size() == 0) begin
				report_error($sformatf("item with none expected, tuser %b tdata %h",
					m_tuser, m_tdata));
			end else begin
				want = frame_q.pop_front();
				check_field("kind", {15'h0, m_tuser[0]}, {15'h0, want.kind});
				check_field("data_byte", {8'h0, m_tdata[7:0]}, {8'h0, want.data_byte});
				check_field("byte_index", {8'h0, m_tdata[15:8]}, {8'h0, want.byte_index});
				check_field("command_code", {8'h0, m_tdata[23:16]}, {8'h0, want.command_code});
				check_field("var_address", m_tdata[39:24], want.var_address);
				check_field("frame_len", {8'h0, m_tdata[47:40]}, {8'h0, want.frame_len});
				check_field("content_len_byte", {8'h0, m_tdata[55:48]},
					{8'h0, want.content_len_byte});
				check_field("check_word", m_tdata[71:56], want.check_word);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned target;
		int unsigned min_frames;
		int unsigned frames;
		fails = 0;
		cycles = 0;
		deep_items = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'b000;
		pwdata = 32'h0;
		ph = PH_HUNT;
		hdr_first = sfd_pkg::HEADER_FIRST_RST;
		hdr_second = sfd_pkg::HEADER_SECOND_RST;
		sub_cnt = 8'd0;
		frm_len = 8'd0;
		cmd_byte = 8'd0;
		var_addr = 16'd0;
		clen_byte = 8'd0;
		chk_hi = 8'd0;

		// shortest frame: length 0, one content byte, extreme bytes
		add_row(sfd_pkg::HEADER_FIRST_RST);
		add_row(sfd_pkg::HEADER_SECOND_RST);
		add_row(8'h00);
		add_row(sfd_pkg::CMD_ONE_BYTE_ADDR);
		add_row(8'hFF);
		add_row(8'h00);
		add_row_exp(8'hFF, sfd_pkg::KIND_CONTENT, 8'hFF, 8'd0, sfd_pkg::CMD_ONE_BYTE_ADDR,
			16'h00FF, 8'h00, 8'h00, 16'h0000);
		add_row(8'hFF);
		add_row_exp(8'h00, sfd_pkg::KIND_DONE, 8'h00, 8'd1, sfd_pkg::CMD_ONE_BYTE_ADDR,
			16'h00FF, 8'h00, 8'h00, 16'hFF00);
		// unknown command drops back to hunting
		add_row(sfd_pkg::HEADER_SECOND_RST);
		add_row(8'h06);
		add_row(8'h77);
		add_row(8'h00);
		// two-byte address, two content bytes
		add_row(sfd_pkg::HEADER_SECOND_RST);
		add_row(8'h08);
		add_row(sfd_pkg::CMD_TWO_BYTE_ADDR);
		add_row(8'h12);
		add_row(8'h34);
		add_row(8'hFF);
		add_row_exp(8'h00, sfd_pkg::KIND_CONTENT, 8'h00, 8'd0, sfd_pkg::CMD_TWO_BYTE_ADDR,
			16'h1234, 8'h08, 8'hFF, 16'h0000);
		add_row_exp(8'h01, sfd_pkg::KIND_CONTENT, 8'h01, 8'd1, sfd_pkg::CMD_TWO_BYTE_ADDR,
			16'h1234, 8'h08, 8'hFF, 16'h0000);
		add_row(8'h00);
		add_row_exp(8'hFF, sfd_pkg::KIND_DONE, 8'h00, 8'd2, sfd_pkg::CMD_TWO_BYTE_ADDR,
			16'h1234, 8'h08, 8'hFF, 16'h00FF);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i])
			send_rx(stim_rows[i].rx, stim_rows[i].typed, stim_rows[i].want);
		drain();

		for (int p = 0; p < 5; p++) begin
			target = 140;
			min_frames = 1;
			case (p)
				0: begin
					write_reg(sfd_pkg::REG_HEADER_FIRST, sfd_pkg::HEADER_FIRST_RST);
					write_reg(sfd_pkg::REG_HEADER_SECOND, sfd_pkg::HEADER_SECOND_RST);
				end
				1: begin
					write_reg(sfd_pkg::REG_HEADER_FIRST, 8'h00);
					write_reg(sfd_pkg::REG_HEADER_SECOND, 8'hFF);
				end
				2: begin
					write_reg(sfd_pkg::REG_HEADER_FIRST, 8'hFF);
					write_reg(sfd_pkg::REG_HEADER_SECOND, 8'h00);
				end
				3: begin
					// equal headers: no frame can start
					write_reg(sfd_pkg::REG_HEADER_FIRST, 8'h33);
					write_reg(sfd_pkg::REG_HEADER_SECOND, 8'h33);
					target = 0;
					min_frames = 8;
				end
				default: begin
					// distinct random headers so frames can start
					write_reg(sfd_pkg::REG_HEADER_FIRST, 8'($urandom_range(255)));
					write_reg(sfd_pkg::REG_HEADER_SECOND,
						hdr_first ^ 8'($urandom_range(1, 255)));
				end
			endcase
			case (p % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 81;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 81;
				end
				default: begin
					src_idle_pct = 22;
					sink_stall_pct = 22;
				end
			endcase
			deep_items = 0;
			frames = 0;
			while (deep_items < target || frames < min_frames) begin
				send_frame();
				frames++;
			end
			drain();
		end

		s_tvalid = 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_parser.sv
hw/rtl/screen_frame_deframer.sv
sim/screen_frame_deframer_tb.sv
